// File: src/sgm_pkg.sv
// Shared constants for the dome mesh generator.
`default_nettype none
package sgm_pkg;

   localparam int MAX_VERTICES_DEF = 4096;
   localparam int TRIG_BITS_DEF    = 16;

   // Width of every divider dividend, and so the divider depth in stages.
   localparam int DIV_W    = 24;
   // Register stages inside one quarter-wave sine unit.
   localparam int SINE_LAT = 7;

   // Taylor terms of sin(pi/2*x) in Q30, highest power last.
   localparam logic [31:0] SINE_COEF [5] = '{
      32'd1686629713, 32'd693598670, 32'd85569306, 32'd5026995, 32'd172272
   };

   localparam logic [2:0] REG_COLUMNS   = 3'd0;
   localparam logic [2:0] REG_ROWS      = 3'd1;
   localparam logic [2:0] REG_TEX_FRAC  = 3'd2;
   localparam logic [2:0] REG_SPH_FRAC  = 3'd3;
   localparam logic [2:0] REG_RADIUS    = 3'd4;

   localparam logic       ACT_VERTEX    = 1'b0;
   localparam logic       ACT_TRIANGLE  = 1'b1;

endpackage
`default_nettype wire

// File: src/sgm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module sgm_div
   import sgm_pkg::*;
#(
   parameter int NUM_W = DIV_W,
   parameter int DEN_W = 7
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic      [NUM_W-1:0] quo
);

   logic [DEN_W-1:0] rem_ff  [NUM_W];
   logic [DEN_W-1:0] rem_in  [NUM_W];
   logic [DEN_W-1:0] rem_pv  [NUM_W];
   logic [NUM_W-1:0] nq_ff   [NUM_W];
   logic [NUM_W-1:0] nq_in   [NUM_W];
   logic [NUM_W-1:0] nq_pv   [NUM_W];
   logic [DEN_W-1:0] den_ff  [NUM_W];
   logic [DEN_W-1:0] den_pv  [NUM_W];
   logic [DEN_W:0]   trial   [NUM_W];
   logic [DEN_W:0]   diff    [NUM_W];
   logic             ge      [NUM_W];

   always_comb begin
      rem_pv[0] = '0;
      nq_pv[0]  = num;
      den_pv[0] = den;
      for (int i = 1; i < NUM_W; i++) begin
         rem_pv[i] = rem_ff[i-1];
         nq_pv[i]  = nq_ff[i-1];
         den_pv[i] = den_ff[i-1];
      end
      // The dividend shifts out at the top while quotient bits fill in below.
      for (int i = 0; i < NUM_W; i++) begin
         trial[i]  = {rem_pv[i], nq_pv[i][NUM_W-1]};
         diff[i]   = trial[i] - {1'b0, den_pv[i]};
         ge[i]     = trial[i] >= {1'b0, den_pv[i]};
         rem_in[i] = ge[i] ? diff[i][DEN_W-1:0] : trial[i][DEN_W-1:0];
         nq_in[i]  = {nq_pv[i][NUM_W-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_W; i++) begin
            rem_ff[i] <= rem_in[i];
            nq_ff[i]  <= nq_in[i];
            den_ff[i] <= den_pv[i];
         end
      end
   end

   assign quo = nq_ff[NUM_W-1];

endmodule
`default_nettype wire

// File: src/sgm_sine.sv
// Pipelined quarter-wave sine by a degree-9 odd polynomial.
`default_nettype none
module sgm_sine
   import sgm_pkg::*;
#(
   parameter int TRIG_BITS = TRIG_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [14:0]          x,
   output logic      [TRIG_BITS-2:0] mag
);

   localparam int TF    = TRIG_BITS - 2;
   localparam int MAG_W = TF + 1;
   localparam int RSH   = 30 - TF;

   logic [14:0]      x_ff   [5];
   logic [31:0]      x2_ff  [4];
   logic [31:0]      t_ff   [4];
   logic [31:0]      t_in   [4];
   logic [31:0]      t_pv   [4];
   logic [63:0]      hprod  [4];
   logic [29:0]      sq;
   logic [46:0]      vprod;
   logic [30:0]      v_in;
   logic [30:0]      v_ff;
   logic [31:0]      rsum;
   logic [MAG_W-1:0] mag_ff;

   always_comb begin
      sq = x * x;
      t_pv[0] = SINE_COEF[4];
      for (int h = 1; h < 4; h++) begin
         t_pv[h] = t_ff[h-1];
      end
      for (int h = 0; h < 4; h++) begin
         hprod[h] = x2_ff[h] * t_pv[h];
         t_in[h]  = SINE_COEF[3-h] - hprod[h][61:30];
      end
      vprod = x_ff[4] * t_ff[3];
      // Values just above one are clamped before rounding.
      if (vprod[46:14] > 33'd1073741824) begin
         v_in = 31'd1073741824;
      end else begin
         v_in = vprod[44:14];
      end
      rsum = {1'b0, v_ff} + (32'd1 << (RSH - 1));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]  <= x;
         x2_ff[0] <= {sq, 2'b00};
         for (int h = 0; h < 4; h++) begin
            x_ff[h+1] <= x_ff[h];
            t_ff[h]   <= t_in[h];
         end
         for (int h = 1; h < 4; h++) begin
            x2_ff[h] <= x2_ff[h-1];
         end
         v_ff   <= v_in;
         mag_ff <= rsum[RSH+MAG_W-1:RSH];
      end
   end

   assign mag = mag_ff;

endmodule
`default_nettype wire

// File: src/sphere_grid_mesh_generator.sv
// Top level of the latitude-longitude dome mesh generator.
//
// Each item is either a vertex request (column, row) answered with a position
// on the dome and texture coordinates, or a triangle request (column, slot)
// answered with three vertex indices, where vertex (k, j) has index
// k*(rows+1)+j. One item enters per cycle unless a stall on the result side
// holds the whole pipeline. A 24-stage bit-per-stage divider forms the angle
// phases and texture coordinates, a 7-stage polynomial unit forms sine and
// cosine, and two multiply stages scale by the radius. Requests outside the
// configured grid return all zeros with bad_request set. The user must write
// registers only while no item is in flight; the block does not enforce it.
`default_nettype none
module sphere_grid_mesh_generator
   import sgm_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int TRIG_BITS    = TRIG_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [6:0]  req_column,
   input  wire logic [6:0]  req_row_or_slot,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [16:0]      rsp_pos_x,
   output logic [16:0]      rsp_pos_y,
   output logic [16:0]      rsp_pos_z,
   output logic [15:0]      rsp_tex_u,
   output logic [15:0]      rsp_tex_v,
   output logic [11:0]      rsp_corner_a,
   output logic [11:0]      rsp_corner_b,
   output logic [11:0]      rsp_corner_c,
   output logic             rsp_bad_request
);

   localparam int TF     = TRIG_BITS - 2;
   localparam int MAG_W  = TF + 1;
   localparam int RC_W   = 16 + MAG_W;
   localparam int PR_W   = RC_W + MAG_W;
   localparam int P_ST   = DIV_W + 1;
   localparam int LAST   = DIV_W + SINE_LAT + 4;
   localparam int GEO_N  = LAST - P_ST + 1;

   typedef struct packed {
      logic        action;
      logic        bad;
      logic [11:0] a;
      logic [11:0] b;
      logic [11:0] c;
   } side_type;

   typedef struct packed {
      logic        nx;
      logic        ny;
      logic        nz;
      logic [15:0] tex_u;
      logic [15:0] tex_v;
   } geo_type;

   // Configuration registers.
   logic [6:0]  columns_ff;
   logic [5:0]  rows_ff;
   logic [15:0] tex_frac_ff;
   logic [15:0] sph_frac_ff;
   logic [15:0] radius_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff  <= 7'd16;
         rows_ff     <= 6'd16;
         tex_frac_ff <= 16'd32768;
         sph_frac_ff <= 16'd16384;
         radius_ff   <= 16'd4096;
      end else if (wr_en) begin
         case (paddr[4:2])
            REG_COLUMNS:  columns_ff  <= pwdata[6:0];
            REG_ROWS:     rows_ff     <= pwdata[5:0];
            REG_TEX_FRAC: tex_frac_ff <= pwdata[15:0];
            REG_SPH_FRAC: sph_frac_ff <= pwdata[15:0];
            REG_RADIUS:   radius_ff   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_COLUMNS:  prdata = {25'd0, columns_ff};
         REG_ROWS:     prdata = {26'd0, rows_ff};
         REG_TEX_FRAC: prdata = {16'd0, tex_frac_ff};
         REG_SPH_FRAC: prdata = {16'd0, sph_frac_ff};
         REG_RADIUS:   prdata = {16'd0, radius_ff};
         default:      prdata = '0;
      endcase
   end

   // Pipeline control: one enable for every stage.
   logic vld_ff [LAST+1];
   logic en;

   assign en        = !(vld_ff[LAST] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i <= LAST; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // Range check and triangle corners at the input.
   logic [14:0] grid_size;
   logic        grid_ok;
   logic [7:0]  slot_max;
   logic        bad_in;
   logic [13:0] base;
   logic [6:0]  jt;
   logic [14:0] ca_sum;
   logic [14:0] cb_sum;
   logic [14:0] cc_sum;
   side_type    side_in;

   always_comb begin
      grid_size = {7'd0, 8'(columns_ff) + 8'd1} * {9'd0, 6'(rows_ff) + 6'd0 + 6'd0}
                  + {7'd0, 8'(columns_ff) + 8'd1};
      grid_ok   = (columns_ff != 7'd0) && (rows_ff != 6'd0)
                  && ({2'b00, grid_size} <= 17'(MAX_VERTICES));
      slot_max  = {1'b0, rows_ff, 1'b0} - 8'd2;
      if (req_action == ACT_VERTEX) begin
         bad_in = !grid_ok || (req_column > columns_ff)
                  || (req_row_or_slot > {1'b0, rows_ff});
      end else begin
         bad_in = !grid_ok || (req_column >= columns_ff)
                  || ({1'b0, req_row_or_slot} > slot_max);
      end
      base = {7'd0, {1'b0, rows_ff} + 7'd1} * {7'd0, req_column};
      // The top triangle and the odd slots share one corner pattern.
      if (req_row_or_slot == 7'd0 || req_row_or_slot[0]) begin
         jt     = 7'((8'(req_row_or_slot) + 8'd1) >> 1);
         ca_sum = {1'b0, base} + {8'd0, jt} + {9'd0, rows_ff} + 15'd2;
         cb_sum = {1'b0, base} + {8'd0, jt} + 15'd1;
      end else begin
         jt     = req_row_or_slot >> 1;
         ca_sum = {1'b0, base} + {8'd0, jt} + {9'd0, rows_ff} + 15'd1;
         cb_sum = {1'b0, base} + {8'd0, jt} + {9'd0, rows_ff} + 15'd2;
      end
      cc_sum = {1'b0, base} + {8'd0, jt};
      side_in.action = req_action;
      side_in.bad    = bad_in;
      side_in.a      = ca_sum[11:0];
      side_in.b      = cb_sum[11:0];
      side_in.c      = cc_sum[11:0];
   end

   side_type    side_ff [LAST+1];
   logic [6:0]  k_ff;
   logic [6:0]  s_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         k_ff       <= req_column;
         s_ff       <= req_row_or_slot;
         for (int i = 1; i <= LAST; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Dividends for the azimuth, elevation and texture v quotients.
   logic [15:0]      sf_sat;
   logic [22:0]      s_sf;
   logic [22:0]      s_tf;
   logic [DIV_W-1:0] num_az;
   logic [DIV_W-1:0] num_el;
   logic [DIV_W-1:0] num_tv;
   logic [DIV_W-1:0] q_az;
   logic [DIV_W-1:0] q_el;
   logic [DIV_W-1:0] q_tv;

   always_comb begin
      sf_sat = (sph_frac_ff > 16'd32768) ? 16'd32768 : sph_frac_ff;
      s_sf   = s_ff * sf_sat;
      s_tf   = s_ff * tex_frac_ff;
      num_az = DIV_W'({k_ff, 17'd0});
      num_el = DIV_W'({s_sf, 1'b0});
      num_tv = DIV_W'({s_tf, 1'b0});
   end

   sgm_div #(.NUM_W(DIV_W), .DEN_W(7)) u_div_az (
      .clock (clock), .en (en), .num (num_az), .den (columns_ff), .quo (q_az)
   );
   sgm_div #(.NUM_W(DIV_W), .DEN_W(7)) u_div_el (
      .clock (clock), .en (en), .num (num_el), .den ({1'b0, rows_ff}), .quo (q_el)
   );
   sgm_div #(.NUM_W(DIV_W), .DEN_W(7)) u_div_tv (
      .clock (clock), .en (en), .num (num_tv), .den ({1'b0, rows_ff}), .quo (q_tv)
   );

   // Phase stage: round the quotients and fold each angle into a quadrant.
   logic [18:0] az_sum;
   logic [17:0] tu_sum;
   logic [17:0] d_sum;
   logic [18:0] tv_sum;
   logic [15:0] az_ph;
   logic [15:0] el_ph;
   logic [13:0] az_r;
   logic [13:0] el_r;
   logic [14:0] az_lo;
   logic [14:0] az_hi;
   logic [14:0] el_lo;
   logic [14:0] el_hi;
   geo_type     geo_in;
   geo_type     geo_ff [GEO_N];
   logic [14:0] arg_sa_ff;
   logic [14:0] arg_ca_ff;
   logic [14:0] arg_se_ff;
   logic [14:0] arg_ce_ff;

   always_comb begin
      az_sum = {1'b0, q_az[17:0]} + 19'd1;
      tu_sum = {1'b0, q_az[17:1]} + 18'd1;
      d_sum  = {1'b0, q_el[16:0]} + 18'd1;
      tv_sum = {1'b0, q_tv[17:0]} + 19'd1;
      az_ph  = az_sum[16:1];
      el_ph  = 16'd16384 - d_sum[16:1];
      az_r   = az_ph[13:0];
      el_r   = el_ph[13:0];
      az_lo  = {1'b0, az_r};
      az_hi  = 15'd16384 - {1'b0, az_r};
      el_lo  = {1'b0, el_r};
      el_hi  = 15'd16384 - {1'b0, el_r};
      // Sine is negative in the lower half turn, cosine in quadrants one and two.
      geo_in.nx    = (el_ph[15] ^ el_ph[14]) != az_ph[15];
      geo_in.ny    = el_ph[15];
      geo_in.nz    = (el_ph[15] ^ el_ph[14]) != (az_ph[15] ^ az_ph[14]);
      geo_in.tex_u = tu_sum[16:1];
      geo_in.tex_v = tv_sum[16:1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         arg_sa_ff <= az_ph[14] ? az_hi : az_lo;
         arg_ca_ff <= az_ph[14] ? az_lo : az_hi;
         arg_se_ff <= el_ph[14] ? el_hi : el_lo;
         arg_ce_ff <= el_ph[14] ? el_lo : el_hi;
         geo_ff[0] <= geo_in;
         for (int i = 1; i < GEO_N; i++) begin
            geo_ff[i] <= geo_ff[i-1];
         end
      end
   end

   logic [MAG_W-1:0] sa_mag;
   logic [MAG_W-1:0] ca_mag;
   logic [MAG_W-1:0] se_mag;
   logic [MAG_W-1:0] ce_mag;

   sgm_sine #(.TRIG_BITS(TRIG_BITS)) u_sine_sa (
      .clock (clock), .en (en), .x (arg_sa_ff), .mag (sa_mag)
   );
   sgm_sine #(.TRIG_BITS(TRIG_BITS)) u_sine_ca (
      .clock (clock), .en (en), .x (arg_ca_ff), .mag (ca_mag)
   );
   sgm_sine #(.TRIG_BITS(TRIG_BITS)) u_sine_se (
      .clock (clock), .en (en), .x (arg_se_ff), .mag (se_mag)
   );
   sgm_sine #(.TRIG_BITS(TRIG_BITS)) u_sine_ce (
      .clock (clock), .en (en), .x (arg_ce_ff), .mag (ce_mag)
   );

   // Radius scaling over two multiply stages.
   logic [RC_W-1:0]  rce_ff;
   logic [RC_W-1:0]  rse_ff;
   logic [MAG_W-1:0] sa_ff;
   logic [MAG_W-1:0] ca_ff;
   logic [PR_W-1:0]  px_ff;
   logic [PR_W-1:0]  pz_ff;
   logic [RC_W-1:0]  py_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rce_ff <= radius_ff * ce_mag;
         rse_ff <= radius_ff * se_mag;
         sa_ff  <= sa_mag;
         ca_ff  <= ca_mag;
         px_ff  <= rce_ff * sa_ff;
         pz_ff  <= rce_ff * ca_ff;
         py_ff  <= rse_ff;
      end
   end

   logic [PR_W:0]   px_rnd;
   logic [PR_W:0]   pz_rnd;
   logic [RC_W:0]   py_rnd;
   logic [PR_W:0]   px_sh;
   logic [PR_W:0]   pz_sh;
   logic [RC_W:0]   py_sh;
   logic [16:0]     mx;
   logic [16:0]     my;
   logic [16:0]     mz;
   side_type        sd;
   geo_type         gd;

   always_comb begin
      sd     = side_ff[LAST-1];
      gd     = geo_ff[GEO_N-2];
      px_rnd = {1'b0, px_ff} + ((PR_W+1)'(1) << (2*TF - 1));
      pz_rnd = {1'b0, pz_ff} + ((PR_W+1)'(1) << (2*TF - 1));
      py_rnd = {1'b0, py_ff} + ((RC_W+1)'(1) << (TF - 1));
      px_sh  = px_rnd >> (2*TF);
      pz_sh  = pz_rnd >> (2*TF);
      py_sh  = py_rnd >> TF;
      mx     = gd.nx ? 17'd0 - px_sh[16:0] : px_sh[16:0];
      my     = gd.ny ? 17'd0 - py_sh[16:0] : py_sh[16:0];
      mz     = gd.nz ? 17'd0 - pz_sh[16:0] : pz_sh[16:0];
   end

   logic [16:0] pos_x_ff;
   logic [16:0] pos_y_ff;
   logic [16:0] pos_z_ff;
   logic [15:0] tex_u_ff;
   logic [15:0] tex_v_ff;
   logic [11:0] corner_a_ff;
   logic [11:0] corner_b_ff;
   logic [11:0] corner_c_ff;
   logic        bad_ff;

   // Fields a result does not use are zero, and a bad request is all zero.
   always_ff @(posedge clock) begin
      if (en) begin
         bad_ff      <= sd.bad;
         pos_x_ff    <= '0;
         pos_y_ff    <= '0;
         pos_z_ff    <= '0;
         tex_u_ff    <= '0;
         tex_v_ff    <= '0;
         corner_a_ff <= '0;
         corner_b_ff <= '0;
         corner_c_ff <= '0;
         if (!sd.bad) begin
            if (sd.action == ACT_TRIANGLE) begin
               corner_a_ff <= sd.a;
               corner_b_ff <= sd.b;
               corner_c_ff <= sd.c;
            end else begin
               pos_x_ff <= mx;
               pos_y_ff <= my;
               pos_z_ff <= mz;
               tex_u_ff <= gd.tex_u;
               tex_v_ff <= gd.tex_v;
            end
         end
      end
   end

   assign rsp_pos_x       = pos_x_ff;
   assign rsp_pos_y       = pos_y_ff;
   assign rsp_pos_z       = pos_z_ff;
   assign rsp_tex_u       = tex_u_ff;
   assign rsp_tex_v       = tex_v_ff;
   assign rsp_corner_a    = corner_a_ff;
   assign rsp_corner_b    = corner_b_ff;
   assign rsp_corner_c    = corner_c_ff;
   assign rsp_bad_request = bad_ff;

endmodule
`default_nettype wire
